>>> hdl/fjt_pkg.sv
package fjt_pkg;

    typedef enum logic [4:0] {
        PH_BEFORE_OBJ   = 5'd0,
        PH_AFTER_BRACE  = 5'd1,
        PH_BEFORE_KEY   = 5'd2,
        PH_STRING       = 5'd3,
        PH_ESCAPE       = 5'd4,
        PH_HEX          = 5'd5,
        PH_LOW_BSL      = 5'd6,
        PH_LOW_U        = 5'd7,
        PH_LOW_HEX      = 5'd8,
        PH_AFTER_KEY    = 5'd9,
        PH_BEFORE_VALUE = 5'd10,
        PH_LITERAL      = 5'd11,
        PH_NUM_MINUS    = 5'd12,
        PH_NUM_INT      = 5'd13,
        PH_NUM_DOT      = 5'd14,
        PH_NUM_FRAC     = 5'd15,
        PH_NUM_E        = 5'd16,
        PH_NUM_ESIGN    = 5'd17,
        PH_NUM_EXP      = 5'd18,
        PH_AFTER_VALUE  = 5'd19,
        PH_DONE         = 5'd20,
        PH_ERROR        = 5'd21
    } phase_t;

    localparam logic [2:0] TAG_KEY_BYTE  = 3'd0;
    localparam logic [2:0] TAG_KEY_END   = 3'd1;
    localparam logic [2:0] TAG_STR_BYTE  = 3'd2;
    localparam logic [2:0] TAG_NUM_CHAR  = 3'd3;
    localparam logic [2:0] TAG_VALUE_END = 3'd4;
    localparam logic [2:0] TAG_VERDICT   = 3'd5;

    localparam logic [1:0] VT_STRING = 2'd0;
    localparam logic [1:0] VT_NUMBER = 2'd1;
    localparam logic [1:0] VT_BOOL   = 2'd2;
    localparam logic [1:0] VT_NULL   = 2'd3;

    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_TOO_LARGE   = 4'd1;
    localparam logic [3:0] ST_EXP_OBJECT  = 4'd2;
    localparam logic [3:0] ST_TRAILING    = 4'd3;
    localparam logic [3:0] ST_TOO_MANY    = 4'd4;
    localparam logic [3:0] ST_BAD_KEY     = 4'd5;
    localparam logic [3:0] ST_EXP_COLON   = 4'd6;
    localparam logic [3:0] ST_BAD_SCALAR  = 4'd7;
    localparam logic [3:0] ST_EXP_COMMA   = 4'd8;

    localparam logic [1:0] REG_MAX_STRING = 2'd0;
    localparam logic [1:0] REG_MAX_NUMBER = 2'd1;
    localparam logic [1:0] REG_MAX_KEYS   = 2'd2;
    localparam logic [1:0] REG_MAX_DOC    = 2'd3;

    typedef struct packed {
        logic [15:0] max_string_bytes;
        logic [7:0]  max_number_chars;
        logic [9:0]  max_keys;
        logic [23:0] max_document_bytes;
    } cfg_t;

    typedef struct packed {
        logic [2:0] tag;
        logic [7:0] out_byte;
        logic [1:0] value_type;
        logic       bool_value;
        logic [3:0] status;
    } token_t;

    typedef struct packed {
        token_t [3:0] tok;
        logic   [2:0] count;
    } token_set_t;

endpackage

>>> hdl/fjt_if.sv
interface fjt_byte_if;
    import fjt_pkg::*;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] doc_byte;
    modport source (output valid, kind, doc_byte, input ready);
    modport sink (input valid, kind, doc_byte, output ready);
endinterface

interface fjt_token_if;
    import fjt_pkg::*;
    logic       valid;
    logic       ready;
    logic [2:0] tag;
    logic [7:0] out_byte;
    logic [1:0] value_type;
    logic       bool_value;
    logic [3:0] status;
    logic       last;
    modport source (output valid, tag, out_byte, value_type, bool_value, status, last,
                    input ready);
    modport sink (input valid, tag, out_byte, value_type, bool_value, status, last,
                  output ready);
endinterface

>>> hdl/fjt_cfg.sv
module fjt_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output fjt_pkg::cfg_t       cfg
);
    import fjt_pkg::*;

    cfg_t       cfg_reg;
    logic       wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_string_bytes   <= 16'd1024;
            cfg_reg.max_number_chars   <= 8'd32;
            cfg_reg.max_keys           <= 10'd64;
            cfg_reg.max_document_bytes <= 24'd65536;
        end
        else if (wr)
        begin
            case (paddr[3:2])
                REG_MAX_STRING: cfg_reg.max_string_bytes   <= pwdata[15:0];
                REG_MAX_NUMBER: cfg_reg.max_number_chars   <= pwdata[7:0];
                REG_MAX_KEYS:   cfg_reg.max_keys           <= pwdata[9:0];
                REG_MAX_DOC:    cfg_reg.max_document_bytes <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_MAX_STRING: prdata = {16'd0, cfg_reg.max_string_bytes};
            REG_MAX_NUMBER: prdata = {24'd0, cfg_reg.max_number_chars};
            REG_MAX_KEYS:   prdata = {22'd0, cfg_reg.max_keys};
            REG_MAX_DOC:    prdata = {8'd0, cfg_reg.max_document_bytes};
            default:        prdata = 32'd0;
        endcase
    end
endmodule

>>> hdl/fjt_core.sv
module fjt_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic                 kind,
    input  logic [7:0]           doc_byte,
    input  fjt_pkg::cfg_t        cfg,
    output fjt_pkg::token_set_t  res
);
    import fjt_pkg::*;

    function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] i);
        logic [7:0] ch;
        ch = 8'd0;
        case (k)
            2'd0:
            begin
                case (i)
                    3'd0: ch = "t"; 3'd1: ch = "r"; 3'd2: ch = "u"; 3'd3: ch = "e";
                    default: ch = 8'd0;
                endcase
            end
            2'd1:
            begin
                case (i)
                    3'd0: ch = "f"; 3'd1: ch = "a"; 3'd2: ch = "l"; 3'd3: ch = "s";
                    3'd4: ch = "e";
                    default: ch = 8'd0;
                endcase
            end
            default:
            begin
                case (i)
                    3'd0: ch = "n"; 3'd1: ch = "u"; 3'd2: ch = "l"; 3'd3: ch = "l";
                    default: ch = 8'd0;
                endcase
            end
        endcase
        return ch;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    phase_t       phase_reg, phase_next;
    logic         in_key_reg, in_key_next;
    logic [1:0]   lit_kind_reg, lit_kind_next;
    logic [2:0]   lit_idx_reg, lit_idx_next;
    logic [15:0]  hex_acc_reg, hex_acc_next;
    logic [1:0]   hex_cnt_reg, hex_cnt_next;
    logic [9:0]   high_sur_reg, high_sur_next;
    logic [16:0]  str_len_reg, str_len_next;
    logic [7:0]   num_len_reg, num_len_next;
    logic         lead_zero_reg, lead_zero_next;
    logic [10:0]  key_cnt_reg, key_cnt_next;
    logic [24:0]  byte_cnt_reg, byte_cnt_next;
    logic [3:0]   err_reg, err_next;

    token_set_t   set;
    logic [3:0]   end_st;
    logic [3:0]   str_err;

    assign res = set;
    assign str_err = in_key_reg ? ST_BAD_KEY : ST_BAD_SCALAR;

    always_comb
    begin
        case (phase_reg)
            PH_BEFORE_OBJ:  end_st = ST_EXP_OBJECT;
            PH_AFTER_BRACE: end_st = (key_cnt_reg >= {1'b0, cfg.max_keys}) ? ST_TOO_MANY
                                                                          : ST_BAD_KEY;
            PH_BEFORE_KEY:  end_st = ST_BAD_KEY;
            PH_STRING, PH_ESCAPE, PH_HEX, PH_LOW_BSL, PH_LOW_U, PH_LOW_HEX:
                            end_st = str_err;
            PH_AFTER_KEY:   end_st = ST_EXP_COLON;
            PH_NUM_INT, PH_NUM_FRAC, PH_NUM_EXP, PH_AFTER_VALUE:
                            end_st = ST_EXP_COMMA;
            PH_DONE:        end_st = ST_OK;
            PH_ERROR:       end_st = err_reg;
            default:        end_st = ST_BAD_SCALAR;
        endcase
    end

    always_comb
    begin
        logic [7:0]  c;
        phase_t      ph;
        logic [2:0]  n;
        logic [1:0]  nr;     // number step: 1 consumed, 2 terminator, 3 error
        logic        do_str;
        logic [7:0]  sb0, sb1, sb2, sb3;
        logic [2:0]  scnt;
        logic [20:0] cp;
        logic        do_cp;
        logic [4:0]  hv;
        logic [17:0] slen;
        logic [16:0] slen_sat;
        logic [1:0]  k;
        logic [2:0]  klen;
        logic [15:0] acc;

        phase_next     = phase_reg;
        in_key_next    = in_key_reg;
        lit_kind_next  = lit_kind_reg;
        lit_idx_next   = lit_idx_reg;
        hex_acc_next   = hex_acc_reg;
        hex_cnt_next   = hex_cnt_reg;
        high_sur_next  = high_sur_reg;
        str_len_next   = str_len_reg;
        num_len_next   = num_len_reg;
        lead_zero_next = lead_zero_reg;
        key_cnt_next   = key_cnt_reg;
        byte_cnt_next  = byte_cnt_reg;
        err_next       = err_reg;
        set            = '0;
        c = doc_byte; ph = phase_reg; n = 3'd0; nr = 2'd0;
        do_str = 1'b0; sb0 = 8'd0; sb1 = 8'd0; sb2 = 8'd0; sb3 = 8'd0; scnt = 3'd0;
        cp = 21'd0; do_cp = 1'b0; hv = 5'd0; slen = 18'd0; slen_sat = 17'd0;
        k = 2'd0; klen = 3'd0; acc = 16'd0;

        if (accept && kind)
        begin
            set.tok[0].tag    = TAG_VERDICT;
            set.tok[0].status = (byte_cnt_reg > {1'b0, cfg.max_document_bytes})
                                ? ST_TOO_LARGE : end_st;
            n = 3'd1;
            phase_next = PH_BEFORE_OBJ; in_key_next = 1'b0; lit_kind_next = 2'd0;
            lit_idx_next = 3'd0; hex_acc_next = 16'd0; hex_cnt_next = 2'd0;
            high_sur_next = 10'd0; str_len_next = 17'd0; num_len_next = 8'd0;
            lead_zero_next = 1'b0; key_cnt_next = 11'd0; byte_cnt_next = 25'd0;
            err_next = ST_OK;
        end
        else if (accept)
        begin
            if (byte_cnt_reg != {25{1'b1}})
                byte_cnt_next = byte_cnt_reg + 25'd1;
            if (phase_reg != PH_ERROR)
            begin
                // number continuation runs first; a terminator falls through
                case (ph)
                    PH_NUM_MINUS:
                    begin
                        if (!is_digit(c)) nr = 2'd3;
                        else
                        begin
                            lead_zero_next = (c == "0"); ph = PH_NUM_INT; nr = 2'd1;
                        end
                    end
                    PH_NUM_INT:
                    begin
                        if (is_digit(c)) nr = lead_zero_reg ? 2'd3 : 2'd1;
                        else if (c == ".") begin ph = PH_NUM_DOT; nr = 2'd1; end
                        else if (c == "e" || c == "E") begin ph = PH_NUM_E; nr = 2'd1; end
                        else nr = 2'd2;
                    end
                    PH_NUM_DOT:
                    begin
                        if (!is_digit(c)) nr = 2'd3;
                        else begin ph = PH_NUM_FRAC; nr = 2'd1; end
                    end
                    PH_NUM_FRAC:
                    begin
                        if (is_digit(c)) nr = 2'd1;
                        else if (c == "e" || c == "E") begin ph = PH_NUM_E; nr = 2'd1; end
                        else nr = 2'd2;
                    end
                    PH_NUM_E:
                    begin
                        if (c == "+" || c == "-") begin ph = PH_NUM_ESIGN; nr = 2'd1; end
                        else if (is_digit(c)) begin ph = PH_NUM_EXP; nr = 2'd1; end
                        else nr = 2'd3;
                    end
                    PH_NUM_ESIGN:
                    begin
                        if (!is_digit(c)) nr = 2'd3;
                        else begin ph = PH_NUM_EXP; nr = 2'd1; end
                    end
                    PH_NUM_EXP: nr = is_digit(c) ? 2'd1 : 2'd2;
                    default: nr = 2'd0;
                endcase

                if (nr == 2'd3)
                begin
                    err_next = ST_BAD_SCALAR; ph = PH_ERROR;
                end
                else if (nr == 2'd1)
                begin
                    if (num_len_reg >= cfg.max_number_chars)
                    begin
                        err_next = ST_BAD_SCALAR; ph = PH_ERROR;
                    end
                    else
                    begin
                        num_len_next = num_len_reg + 8'd1;
                        set.tok[n[1:0]].tag = TAG_NUM_CHAR;
                        set.tok[n[1:0]].out_byte = c;
                        n = n + 3'd1;
                    end
                end
                else
                begin
                    if (nr == 2'd2)
                    begin
                        set.tok[n[1:0]].tag = TAG_VALUE_END;
                        set.tok[n[1:0]].value_type = VT_NUMBER;
                        n = n + 3'd1;
                        if (key_cnt_reg != 11'h7FF) key_cnt_next = key_cnt_reg + 11'd1;
                        ph = PH_AFTER_VALUE;
                    end
                    case (ph)
                        PH_BEFORE_OBJ:
                        begin
                            if (!is_ws(c))
                            begin
                                if (c == "{") ph = PH_AFTER_BRACE;
                                else begin err_next = ST_EXP_OBJECT; ph = PH_ERROR; end
                            end
                        end
                        PH_AFTER_BRACE, PH_BEFORE_KEY:
                        begin
                            if (!is_ws(c))
                            begin
                                if (ph == PH_AFTER_BRACE && c == "}") ph = PH_DONE;
                                else if (ph == PH_AFTER_BRACE &&
                                         key_cnt_reg >= {1'b0, cfg.max_keys})
                                begin
                                    err_next = ST_TOO_MANY; ph = PH_ERROR;
                                end
                                else if (c == "\"")
                                begin
                                    in_key_next = 1'b1; str_len_next = 17'd0; ph = PH_STRING;
                                end
                                else begin err_next = ST_BAD_KEY; ph = PH_ERROR; end
                            end
                        end
                        PH_STRING:
                        begin
                            if (c == "\"")
                            begin
                                if (in_key_reg)
                                begin
                                    set.tok[n[1:0]].tag = TAG_KEY_END;
                                    n = n + 3'd1;
                                    ph = PH_AFTER_KEY;
                                end
                                else
                                begin
                                    set.tok[n[1:0]].tag = TAG_VALUE_END;
                                    set.tok[n[1:0]].value_type = VT_STRING;
                                    n = n + 3'd1;
                                    if (key_cnt_reg != 11'h7FF)
                                        key_cnt_next = key_cnt_reg + 11'd1;
                                    ph = PH_AFTER_VALUE;
                                end
                            end
                            else if (c < 8'h20) begin err_next = str_err; ph = PH_ERROR; end
                            else if (c == "\\") ph = PH_ESCAPE;
                            else begin sb0 = c; scnt = 3'd1; do_str = 1'b1; end
                        end
                        PH_ESCAPE:
                        begin
                            ph = PH_STRING; scnt = 3'd1; do_str = 1'b1;
                            case (c)
                                "\"", "\\", "/": sb0 = c;
                                "b": sb0 = 8'h08;
                                "f": sb0 = 8'h0C;
                                "n": sb0 = 8'h0A;
                                "r": sb0 = 8'h0D;
                                "t": sb0 = 8'h09;
                                "u":
                                begin
                                    do_str = 1'b0; ph = PH_HEX;
                                    hex_cnt_next = 2'd0; hex_acc_next = 16'd0;
                                end
                                default:
                                begin
                                    do_str = 1'b0; err_next = str_err; ph = PH_ERROR;
                                end
                            endcase
                        end
                        PH_HEX, PH_LOW_HEX:
                        begin
                            if (is_digit(c)) hv = {1'b1, c[3:0]};
                            else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
                                hv = {1'b1, c[3:0] + 4'd9};
                            if (!hv[4]) begin err_next = str_err; ph = PH_ERROR; end
                            else
                            begin
                                acc = {hex_acc_reg[11:0], hv[3:0]};
                                hex_acc_next = acc;
                                if (hex_cnt_reg != 2'd3) hex_cnt_next = hex_cnt_reg + 2'd1;
                                else
                                begin
                                    hex_cnt_next = 2'd0;
                                    if (ph == PH_HEX)
                                    begin
                                        if (acc >= 16'hD800 && acc <= 16'hDBFF)
                                        begin
                                            high_sur_next = acc[9:0];
                                            ph = PH_LOW_BSL;
                                        end
                                        else if (acc >= 16'hDC00 && acc <= 16'hDFFF)
                                        begin
                                            err_next = str_err; ph = PH_ERROR;
                                        end
                                        else
                                        begin
                                            ph = PH_STRING; cp = {5'd0, acc}; do_cp = 1'b1;
                                        end
                                    end
                                    else if (acc < 16'hDC00 || acc > 16'hDFFF)
                                    begin
                                        err_next = str_err; ph = PH_ERROR;
                                    end
                                    else
                                    begin
                                        ph = PH_STRING;
                                        cp = 21'h10000 + {1'b0, high_sur_reg, acc[9:0]};
                                        do_cp = 1'b1;
                                    end
                                end
                            end
                        end
                        PH_LOW_BSL:
                        begin
                            if (c == "\\") ph = PH_LOW_U;
                            else begin err_next = str_err; ph = PH_ERROR; end
                        end
                        PH_LOW_U:
                        begin
                            if (c == "u")
                            begin
                                ph = PH_LOW_HEX; hex_cnt_next = 2'd0; hex_acc_next = 16'd0;
                            end
                            else begin err_next = str_err; ph = PH_ERROR; end
                        end
                        PH_AFTER_KEY:
                        begin
                            if (!is_ws(c))
                            begin
                                if (c == ":") ph = PH_BEFORE_VALUE;
                                else begin err_next = ST_EXP_COLON; ph = PH_ERROR; end
                            end
                        end
                        PH_BEFORE_VALUE:
                        begin
                            if (is_ws(c)) ph = PH_BEFORE_VALUE;
                            else if (c == "\"")
                            begin
                                in_key_next = 1'b0; str_len_next = 17'd0; ph = PH_STRING;
                            end
                            else if (c == "t" || c == "f" || c == "n")
                            begin
                                lit_kind_next = (c == "t") ? 2'd0 : (c == "f") ? 2'd1 : 2'd2;
                                lit_idx_next = 3'd1; ph = PH_LITERAL;
                            end
                            else if (c == "-" || is_digit(c))
                            begin
                                lead_zero_next = (c == "0");
                                ph = (c == "-") ? PH_NUM_MINUS : PH_NUM_INT;
                                if (cfg.max_number_chars == 8'd0)
                                begin
                                    num_len_next = 8'd0;
                                    err_next = ST_BAD_SCALAR; ph = PH_ERROR;
                                end
                                else
                                begin
                                    num_len_next = 8'd1;
                                    set.tok[n[1:0]].tag = TAG_NUM_CHAR;
                                    set.tok[n[1:0]].out_byte = c;
                                    n = n + 3'd1;
                                end
                            end
                            else begin err_next = ST_BAD_SCALAR; ph = PH_ERROR; end
                        end
                        PH_LITERAL:
                        begin
                            k = (lit_kind_reg == 2'd3) ? 2'd2 : lit_kind_reg;
                            klen = (k == 2'd1) ? 3'd5 : 3'd4;
                            if (lit_idx_reg >= klen || c != lit_char(k, lit_idx_reg))
                            begin
                                err_next = ST_BAD_SCALAR; ph = PH_ERROR;
                            end
                            else
                            begin
                                lit_idx_next = lit_idx_reg + 3'd1;
                                if (lit_idx_reg + 3'd1 == klen)
                                begin
                                    set.tok[n[1:0]].tag = TAG_VALUE_END;
                                    set.tok[n[1:0]].value_type = (k == 2'd2) ? VT_NULL : VT_BOOL;
                                    set.tok[n[1:0]].bool_value = (k == 2'd0);
                                    n = n + 3'd1;
                                    if (key_cnt_reg != 11'h7FF)
                                        key_cnt_next = key_cnt_reg + 11'd1;
                                    ph = PH_AFTER_VALUE;
                                end
                            end
                        end
                        PH_AFTER_VALUE:
                        begin
                            if (!is_ws(c))
                            begin
                                if (c == ",")
                                begin
                                    // the count may include the value just closed
                                    if (key_cnt_next >= {1'b0, cfg.max_keys})
                                    begin
                                        err_next = ST_TOO_MANY; ph = PH_ERROR;
                                    end
                                    else ph = PH_BEFORE_KEY;
                                end
                                else if (c == "}") ph = PH_DONE;
                                else begin err_next = ST_EXP_COMMA; ph = PH_ERROR; end
                            end
                        end
                        PH_DONE:
                        begin
                            if (!is_ws(c)) begin err_next = ST_TRAILING; ph = PH_ERROR; end
                        end
                        default: ;
                    endcase

                    // utf-8 encode of a decoded code point
                    if (do_cp)
                    begin
                        do_str = 1'b1;
                        if (cp <= 21'h7F) begin sb0 = cp[7:0]; scnt = 3'd1; end
                        else if (cp <= 21'h7FF)
                        begin
                            sb0 = 8'hC0 | {3'd0, cp[10:6]}; sb1 = 8'h80 | {2'd0, cp[5:0]};
                            scnt = 3'd2;
                        end
                        else if (cp <= 21'hFFFF)
                        begin
                            sb0 = 8'hE0 | {4'd0, cp[15:12]};
                            sb1 = 8'h80 | {2'd0, cp[11:6]};
                            sb2 = 8'h80 | {2'd0, cp[5:0]};
                            scnt = 3'd3;
                        end
                        else
                        begin
                            sb0 = 8'hF0 | {5'd0, cp[20:18]};
                            sb1 = 8'h80 | {2'd0, cp[17:12]};
                            sb2 = 8'h80 | {2'd0, cp[11:6]};
                            sb3 = 8'h80 | {2'd0, cp[5:0]};
                            scnt = 3'd4;
                        end
                    end

                    if (do_str)
                    begin
                        slen = {1'b0, str_len_reg} + {15'd0, scnt};
                        slen_sat = slen[17] ? {17{1'b1}} : slen[16:0];
                        str_len_next = slen_sat;
                        if (slen_sat > {1'b0, cfg.max_string_bytes})
                        begin
                            err_next = str_err; ph = PH_ERROR;
                        end
                        else
                        begin
                            set.tok[0].tag = in_key_reg ? TAG_KEY_BYTE : TAG_STR_BYTE;
                            set.tok[0].out_byte = sb0;
                            set.tok[1].tag = in_key_reg ? TAG_KEY_BYTE : TAG_STR_BYTE;
                            set.tok[1].out_byte = sb1;
                            set.tok[2].tag = in_key_reg ? TAG_KEY_BYTE : TAG_STR_BYTE;
                            set.tok[2].out_byte = sb2;
                            set.tok[3].tag = in_key_reg ? TAG_KEY_BYTE : TAG_STR_BYTE;
                            set.tok[3].out_byte = sb3;
                            n = scnt;
                        end
                    end
                end
                phase_next = ph;
            end
        end
        set.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_BEFORE_OBJ;
            in_key_reg    <= 1'b0;
            lit_kind_reg  <= 2'd0;
            lit_idx_reg   <= 3'd0;
            hex_acc_reg   <= 16'd0;
            hex_cnt_reg   <= 2'd0;
            high_sur_reg  <= 10'd0;
            str_len_reg   <= 17'd0;
            num_len_reg   <= 8'd0;
            lead_zero_reg <= 1'b0;
            key_cnt_reg   <= 11'd0;
            byte_cnt_reg  <= 25'd0;
            err_reg       <= ST_OK;
        end
        else
        begin
            phase_reg     <= phase_next;
            in_key_reg    <= in_key_next;
            lit_kind_reg  <= lit_kind_next;
            lit_idx_reg   <= lit_idx_next;
            hex_acc_reg   <= hex_acc_next;
            hex_cnt_reg   <= hex_cnt_next;
            high_sur_reg  <= high_sur_next;
            str_len_reg   <= str_len_next;
            num_len_reg   <= num_len_next;
            lead_zero_reg <= lead_zero_next;
            key_cnt_reg   <= key_cnt_next;
            byte_cnt_reg  <= byte_cnt_next;
            err_reg       <= err_next;
        end
    end
endmodule

>>> hdl/fjt_outbuf.sv
module fjt_outbuf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  fjt_pkg::token_set_t  set,
    output logic                 can_load,
    fjt_token_if.source          tokens
);
    import fjt_pkg::*;

    token_t [3:0] tok_reg;
    logic   [2:0] cnt_reg;
    logic   [2:0] pos_reg;
    logic   [2:0] pos_next;
    logic         fire;

    assign tokens.valid      = pos_reg < cnt_reg;
    assign tokens.tag        = tok_reg[pos_reg[1:0]].tag;
    assign tokens.out_byte   = tok_reg[pos_reg[1:0]].out_byte;
    assign tokens.value_type = tok_reg[pos_reg[1:0]].value_type;
    assign tokens.bool_value = tok_reg[pos_reg[1:0]].bool_value;
    assign tokens.status     = tok_reg[pos_reg[1:0]].status;
    assign tokens.last       = (pos_reg + 3'd1 == cnt_reg);

    assign fire     = tokens.valid && tokens.ready;
    assign pos_next = pos_reg + 3'd1;
    // free now, or the final pending transaction leaves this cycle
    assign can_load = !tokens.valid || (fire && tokens.last);

    always_ff @(posedge clk)
    begin
        if (load)
            tok_reg <= set.tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
            pos_reg <= 3'd0;
        end
        else if (load)
        begin
            cnt_reg <= set.count;
            pos_reg <= 3'd0;
        end
        else if (fire)
            pos_reg <= pos_next;
    end

    a_load_restart: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> pos_reg == 3'd0)
        else $error("position not cleared on load");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4 && pos_reg <= cnt_reg)
        else $error("buffer position out of range");
    a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
        tokens.valid && tokens.tag == TAG_VERDICT |-> tokens.last)
        else $error("verdict not final");
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !tokens.valid |-> can_load)
        else $error("stalled while empty");
endmodule

>>> hdl/flat_json_object_tokenizer_top.sv
// Tokenizes one flat JSON object per document, one byte per transaction; a kind=1
// transaction ends the document, yields the verdict and resets the parse state. Each
// byte is parsed in the cycle it is accepted and its tokens (zero to four) are loaded
// into a four-entry output buffer, so a byte producing zero or one token is taken every
// cycle while the token sink is ready; a byte producing several tokens (multi-byte UTF-8
// from a \u escape) holds the input until its last token leaves the buffer. Limits are
// written over APB at
// 0x0 max_string_bytes, 0x4 max_number_chars, 0x8 max_keys, 0xC max_document_bytes.
module flat_json_object_tokenizer_top (
    input  logic         clk,
    input  logic         rst_n,
    fjt_byte_if.sink     bytes,
    fjt_token_if.source  tokens,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import fjt_pkg::*;

    cfg_t        cfg;
    token_set_t  set;
    logic        can_load;
    logic        accept;

    assign bytes.ready = can_load;
    assign accept      = bytes.valid && can_load;

    fjt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fjt_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .kind     (bytes.kind),
        .doc_byte (bytes.doc_byte),
        .cfg      (cfg),
        .res      (set)
    );

    fjt_outbuf u_outbuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .set      (set),
        .can_load (can_load),
        .tokens   (tokens)
    );
endmodule
